// ----- rtl/stbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and sequencer states for the sorted table search block.
// No dependencies.
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	localparam int SUM_W       = ADDR_W + 2;
	localparam int FIELD_W     = 32;
	localparam int INDEX_W     = 10;
	localparam int POS_W       = 10;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic [ADDR_W:0]               bound_t;

	typedef struct packed {
		logic                      opcode;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [FIELD_W-1:0] entry_value;
		logic signed [FIELD_W-1:0] search_key;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} res_t;

	typedef struct packed {
		logic ready;
		logic done;
	} eng_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} eng_state_t;

endpackage

// ----- rtl/stbs_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on stbs_pkg for field widths.
interface stbs_req_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        opcode;
	logic [stbs_pkg::INDEX_W-1:0]                entry_index;
	logic signed [stbs_pkg::FIELD_W-1:0]         entry_value;
	logic signed [stbs_pkg::FIELD_W-1:0]         search_key;
	modport source(output valid, opcode, entry_index, entry_value, search_key, input ready);
	modport sink(input valid, opcode, entry_index, entry_value, search_key, output ready);
endinterface

interface stbs_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [stbs_pkg::POS_W-1:0] position;
	modport source(output valid, found, position, input ready);
	modport sink(input valid, found, position, output ready);
endinterface

interface stbs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [stbs_pkg::CNT_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- rtl/stbs_engine.sv -----
`timescale 1ns / 1ps
// Table memory plus probe sequencer: one read and one compare per probe.
// Depends on stbs_pkg.
module stbs_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  stbs_pkg::req_t             item,
	input  logic [stbs_pkg::CNT_W-1:0] entry_count,
	input  logic                       take,
	output stbs_pkg::eng_stat_t        stat,
	output stbs_pkg::res_t             result
);

	stbs_pkg::val_t               mem [stbs_pkg::TABLE_DEPTH];
	stbs_pkg::val_t               rdata_q;
	logic [stbs_pkg::ADDR_W-1:0]  rd_addr;

	stbs_pkg::eng_state_t state_q, state_d;
	stbs_pkg::bound_t     first_q, first_d;
	stbs_pkg::bound_t     hi_q, hi_d;
	stbs_pkg::bound_t     mid_q, mid_d;
	stbs_pkg::val_t       key_q, key_d;
	stbs_pkg::res_t       res_q, res_d;

	logic [stbs_pkg::SUM_W-1:0] sum;
	stbs_pkg::bound_t           mid;
	stbs_pkg::bound_t           n_sat;
	logic                       wr_en;

	assign wr_en = start && (item.opcode == stbs_pkg::OP_WRITE)
		&& ({1'b0, item.entry_index} < (stbs_pkg::INDEX_W+1)'(stbs_pkg::TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item.entry_index[stbs_pkg::ADDR_W-1:0]] <= stbs_pkg::val_t'(item.entry_value);
		end
		rdata_q <= mem[rd_addr];
	end

	assign n_sat = (entry_count > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
		? (stbs_pkg::ADDR_W+1)'(stbs_pkg::TABLE_DEPTH)
		: (stbs_pkg::ADDR_W+1)'(entry_count);

	// range is first .. hi-1; only probed when first < hi
	assign sum     = stbs_pkg::SUM_W'(first_q) + stbs_pkg::SUM_W'(hi_q) - stbs_pkg::SUM_W'(1);
	assign mid     = sum[stbs_pkg::SUM_W-1:1];
	assign rd_addr = mid[stbs_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		key_q   <= key_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		key_d   = key_q;
		res_d   = res_q;
		unique case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (start && (item.opcode == stbs_pkg::OP_SEARCH)) begin
					first_d = '0;
					hi_d    = n_sat;
					key_d   = stbs_pkg::val_t'(item.search_key);
					state_d = stbs_pkg::ST_READ;
				end
			end
			stbs_pkg::ST_READ: begin
				if (first_q >= hi_q) begin
					res_d   = '0;
					state_d = stbs_pkg::ST_DONE;
				end else begin
					mid_d   = mid;
					state_d = stbs_pkg::ST_CMP;
				end
			end
			stbs_pkg::ST_CMP: begin
				if (key_q == rdata_q) begin
					res_d.found    = 1'b1;
					res_d.position = stbs_pkg::POS_W'(mid_q);
					state_d        = stbs_pkg::ST_DONE;
				end else begin
					if (key_q < rdata_q) begin
						hi_d = mid_q;
					end else begin
						first_d = mid_q + stbs_pkg::bound_t'(1);
					end
					state_d = stbs_pkg::ST_READ;
				end
			end
			stbs_pkg::ST_DONE: begin
				if (take) begin
					state_d = stbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stbs_pkg::ST_IDLE;
			end
		endcase
	end

	assign stat.ready = (state_q == stbs_pkg::ST_IDLE);
	assign stat.done  = (state_q == stbs_pkg::ST_DONE);
	assign result     = res_q;

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
`timescale 1ns / 1ps
// Write item: stored, no result. Search item: p probes (at most 11 for 1024 entries),
// each a registered table read, then a compare. A result loads the output register once
// that register is empty or being read; the next item is taken after the sequencer is back
// in idle. No item is taken while a search runs or while a finished result waits on a full
// output register. Reset clears the entry count, the sequencer and the output valid; table
// contents are undefined until written.
module sorted_table_binary_search (
	input  logic        clk,
	input  logic        arst_n,
	stbs_cfg_if.sink    cfg,
	stbs_req_if.sink    req,
	stbs_rsp_if.source  rsp
);

	logic [stbs_pkg::CNT_W-1:0] count_q;
	stbs_pkg::req_t             item;
	stbs_pkg::eng_stat_t        stat;
	stbs_pkg::res_t             eng_res;
	stbs_pkg::res_t             rsp_q;
	logic                       rsp_valid_q;
	logic                       start;
	logic                       take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	assign item.opcode      = req.opcode;
	assign item.entry_index = req.entry_index;
	assign item.entry_value = req.entry_value;
	assign item.search_key  = req.search_key;

	assign req.ready = stat.ready;
	assign start     = req.valid && stat.ready;
	assign take      = stat.done && (!rsp_valid_q || rsp.ready);

	stbs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.entry_count (count_q),
		.take        (take),
		.stat        (stat),
		.result      (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_q.found;
	assign rsp.position = rsp_q.position;

endmodule

// ----- tb/sorted_table_binary_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_binary_search: fills the table, sets the entry count,
// runs searches under random flow control and checks each result against a scoreboard model.
// Depends on stbs_pkg, the stbs_*_if interfaces and the block itself.
module sorted_table_binary_search_tb;
	import stbs_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE      = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 1750;
	localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fffffff;

	class search_scoreboard;
		val_t  entries[TABLE_DEPTH];
		int    count_reg;
		res_t  awaited[$];
		int    checked;
		int    hits;

		function void set_count(logic [CNT_W-1:0] n);
			count_reg = n;
		endfunction

		function void note_request(req_t r);
			res_t e;
			val_t key;
			int lo, hi, mid, n;
			if (r.opcode == OP_WRITE) begin
				if (r.entry_index < TABLE_DEPTH)
					entries[r.entry_index] = val_t'(r.entry_value);
				return;
			end
			key = val_t'(r.search_key);
			n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
			e = '0;
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (key == entries[mid]) begin
					e.found = 1'b1;
					e.position = mid[POS_W-1:0];
					break;
				end
				if (key < entries[mid])
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			awaited.push_back(e);
		endfunction

		function string check_result(logic f, logic [POS_W-1:0] p);
			res_t e;
			if (awaited.size() == 0)
				return $sformatf("result with nothing pending: found=%0b position=%0d", f, p);
			e = awaited.pop_front();
			checked++;
			if (e.found)
				hits++;
			if (f !== e.found || p !== e.position)
				return $sformatf("result %0d: got found=%0b position=%0d, want found=%0b position=%0d",
					checked, f, p, e.found, e.position);
			return "";
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stbs_cfg_if cfg_ch();
	stbs_req_if req_ch();
	stbs_rsp_if rsp_ch();

	sorted_table_binary_search uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	search_scoreboard sb = new();
	val_t tbl_img[TABLE_DEPTH];
	int   cur_count;
	int   items_sent;
	int   settings;
	int   errors;
	int   quiet;
	bit   gaps_on;
	bit   hold_rsp;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request('{req_ch.opcode, req_ch.entry_index, req_ch.entry_value,
				req_ch.search_key});
	end

	always @(posedge clk) begin
		string msg;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			msg = sb.check_result(rsp_ch.found, rsp_ch.position);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			sb.set_count(cfg_ch.data);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 37);
			end
		end
	end

	task automatic send_req(input logic op, input int idx, input logic signed [FIELD_W-1:0] v,
			input logic signed [FIELD_W-1:0] key);
		while (gaps_on && $urandom_range(0, 99) < 37) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.entry_index <= idx[INDEX_W-1:0];
		req_ch.entry_value <= v;
		req_ch.search_key  <= key;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic put_entry(input int idx, input logic signed [FIELD_W-1:0] v);
		send_req(OP_WRITE, idx, v, $urandom);
		tbl_img[idx] = val_t'(v);
	endtask

	task automatic look_up(input logic signed [FIELD_W-1:0] key);
		send_req(OP_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), $urandom, key);
	endtask

	// wait out every pending search, then let a trailing write retire
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input int n);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= n[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_count = n;
		settings++;
	endtask

	task automatic load_sorted(input int n, input logic signed [FIELD_W-1:0] start,
			input int shift);
		longint acc;
		acc = start;
		for (int i = 0; i < n; i++) begin
			put_entry(i, acc[FIELD_W-1:0]);
			if ($urandom_range(0, 5) != 0)
				acc += longint'($urandom_range(1, 7) << shift);
			if (acc > longint'(VAL_MAX))
				acc = VAL_MAX;
		end
	endtask

	function automatic logic signed [FIELD_W-1:0] pick_key(input int n);
		int r;
		int k;
		r = $urandom_range(0, 9);
		k = (n > 0) ? $urandom_range(0, n - 1) : 0;
		if (n > 0 && r < 5)
			return tbl_img[k];
		if (n > 0 && r < 7)
			return tbl_img[k] + ((r == 5) ? 1 : -1);
		if (r == 7)
			return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		return $urandom;
	endfunction

	// whole table is written by now, so stray writes anywhere are legal
	task automatic run_searches(input int num);
		int n;
		for (int j = 0; j < num; j++) begin
			if ($urandom_range(0, 15) == 0)
				put_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
			n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
			look_up(pick_key(n));
		end
	endtask

	initial begin
		int kind;
		int n;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_WRITE;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		req_ch.search_key  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		gaps_on            = 1'b1;
		hold_rsp           = 1'b0;
		cur_count          = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty table straight out of reset
		look_up(VAL_MIN);
		look_up(VAL_MAX);
		put_entry(TABLE_DEPTH - 1, VAL_MAX);
		put_entry(0, VAL_MIN);
		look_up(0);
		set_count(1);
		look_up(VAL_MIN);
		look_up(VAL_MAX);
		look_up(0);
		put_entry(1, -1);
		put_entry(2, 0);
		put_entry(3, 1);
		set_count(4);
		look_up(VAL_MIN);
		look_up(-1);
		look_up(0);
		look_up(1);
		look_up(-2);
		look_up(2);
		look_up(VAL_MAX);

		// full table, no flow-control gaps
		gaps_on = 1'b0;
		load_sorted(TABLE_DEPTH, VAL_MIN, 20);
		put_entry(TABLE_DEPTH - 1, VAL_MAX);
		set_count(TABLE_DEPTH);
		run_searches(60);
		set_count(2047);
		run_searches(30);
		gaps_on = 1'b1;

		// result side holds off while searches keep coming
		set_count(TABLE_DEPTH - 1);
		hold_rsp = 1'b1;
		run_searches(40);
		set_count(0);
		run_searches(3);

		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			n = $urandom_range(1, 40);
			if (kind == 0) begin
				for (int i = 0; i < n; i++)
					put_entry(i, $urandom);
				set_count(n);
			end else if (kind == 1) begin
				set_count($urandom_range(0, 2047));
			end else begin
				load_sorted(n, $urandom, $urandom_range(0, 24));
				set_count(n);
			end
			run_searches($urandom_range(4, 24));
		end

		drain();
		$display("covered %0d requests over %0d entry-count settings", items_sent, settings);
		$display("checked %0d search results, %0d of them hits", sb.checked, sb.hits);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/stbs_pkg.sv
rtl/stbs_ifs.sv
rtl/stbs_engine.sv
rtl/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
